// ----- rtl/vn_pkg.sv -----
`default_nettype none
package vn_pkg;

  localparam int IN_W    = 32;
  localparam int OUT_W   = 16;
  localparam int SQ_W    = 2 * IN_W;
  localparam int ROOT_W  = IN_W;
  localparam int REM_W   = ROOT_W + 2;
  localparam int RSTEPS  = ROOT_W;
  localparam int QSTEPS  = OUT_W;
  localparam int DEN_W   = IN_W + OUT_W - 1;
  localparam int MINL_W  = 16;
  localparam int LANES   = 3;

  // Item moving through the square root chain.
  typedef struct packed {
    logic                         valid;
    logic [SQ_W-1:0]              n;
    logic [REM_W-1:0]             rem;
    logic [ROOT_W-1:0]            root;
    logic [LANES-1:0][IN_W-1:0]   mag;
    logic [LANES-1:0]             neg;
  } sq_t;

  // Item moving through the divider chain.
  typedef struct packed {
    logic                         valid;
    logic                         degen;
    logic [LANES-1:0]             neg;
    logic [LANES-1:0][DEN_W-1:0]  rem;
    logic [LANES-1:0][OUT_W-1:0]  q;
    logic [DEN_W-1:0]             dsr;
  } dv_t;

endpackage
`default_nettype wire

// ----- rtl/vn_sqrt_cell.sv -----
`default_nettype none
module vn_sqrt_cell
  import vn_pkg::*;
(
  input  wire logic clk_i,
  input  wire logic rst_ni,
  input  wire logic en_i,
  input  wire sq_t  d_i,
  output sq_t       q_o
);

  logic [REM_W+1:0] rem_sh;
  logic [REM_W+1:0] trial;
  sq_t              nxt;

  // One root bit per cell: bring down two radicand bits and try 4r+1.
  always_comb begin
    nxt        = d_i;
    rem_sh     = {d_i.rem, d_i.n[SQ_W-1 -: 2]};
    trial      = {2'b00, d_i.root, 2'b01};
    nxt.n      = {d_i.n[SQ_W-3:0], 2'b00};
    if (rem_sh >= trial) begin
      nxt.rem  = REM_W'(rem_sh - trial);
      nxt.root = {d_i.root[ROOT_W-2:0], 1'b1};
    end else begin
      nxt.rem  = rem_sh[REM_W-1:0];
      nxt.root = {d_i.root[ROOT_W-2:0], 1'b0};
    end
  end

  // Only the valid bit is cleared by reset; the payload just follows it.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      q_o.valid <= 1'b0;
    end else if (en_i) begin
      q_o <= nxt;
    end
  end

endmodule
`default_nettype wire

// ----- rtl/vn_div_cell.sv -----
`default_nettype none
module vn_div_cell
  import vn_pkg::*;
(
  input  wire logic clk_i,
  input  wire logic rst_ni,
  input  wire logic en_i,
  input  wire dv_t  d_i,
  output dv_t       q_o
);

  dv_t nxt;

  // One quotient bit per lane per cell; the divisor walks down one bit.
  always_comb begin
    nxt     = d_i;
    nxt.dsr = {1'b0, d_i.dsr[DEN_W-1:1]};
    for (int k = 0; k < LANES; k++) begin
      if (d_i.rem[k] >= d_i.dsr) begin
        nxt.rem[k] = d_i.rem[k] - d_i.dsr;
        nxt.q[k]   = {d_i.q[k][OUT_W-2:0], 1'b1};
      end else begin
        nxt.q[k]   = {d_i.q[k][OUT_W-2:0], 1'b0};
      end
    end
  end

  // Only the valid bit is cleared by reset; the payload just follows it.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      q_o.valid <= 1'b0;
    end else if (en_i) begin
      q_o <= nxt;
    end
  end

endmodule
`default_nettype wire

// ----- rtl/vector3_normalize.sv -----
// Pipeline: 3 front stages, 32 root cells, 16 divider cells and 1 output
// register; one item per cycle while the output is not stalled.
// The whole pipeline advances together, so a stalled output holds every stage.
// Reset (asynchronous, active low) clears all valid bits and sets min_length
// to zero; payload registers are not reset.
`default_nettype none
module vector3_normalize
  import vn_pkg::*;
(
  input  wire logic                     clk_i,
  input  wire logic                     rst_ni,
  input  wire logic                     cfg_valid_i,
  output      logic                     cfg_ready_o,
  input  wire logic [MINL_W-1:0]        cfg_data_i,
  input  wire logic                     in_valid_i,
  output      logic                     in_ready_o,
  input  wire logic signed [IN_W-1:0]   x_in_i,
  input  wire logic signed [IN_W-1:0]   y_in_i,
  input  wire logic signed [IN_W-1:0]   z_in_i,
  output      logic                     out_valid_o,
  input  wire logic                     out_ready_i,
  output      logic signed [OUT_W-1:0]  x_out_o,
  output      logic signed [OUT_W-1:0]  y_out_o,
  output      logic signed [OUT_W-1:0]  z_out_o,
  output      logic                     degenerate_o
);

  logic [MINL_W-1:0] min_len_q;
  logic              en;

  // The pipeline moves whenever the output register is empty or is drained.
  assign en          = !out_valid_o || out_ready_i;
  assign in_ready_o  = en;
  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      min_len_q <= '0;
    end else if (cfg_valid_i) begin
      min_len_q <= cfg_data_i;
    end
  end

  // Front stage 1: sign and magnitude of each component.
  logic [LANES-1:0][IN_W-1:0] in_vec;
  logic [LANES-1:0][IN_W-1:0] mag_q;
  logic [LANES-1:0]           neg_q;
  logic                       v1_q, v2_q, v3_q;

  assign in_vec = {z_in_i, y_in_i, x_in_i};

  always_ff @(posedge clk_i) begin
    if (en) begin
      for (int k = 0; k < LANES; k++) begin
        neg_q[k] <= in_vec[k][IN_W-1];
        mag_q[k] <= in_vec[k][IN_W-1] ? IN_W'(-in_vec[k]) : in_vec[k];
      end
    end
  end

  // Front stage 2: one multiplier per component.
  logic [LANES-1:0][SQ_W-1:0] sqr_q;
  logic [LANES-1:0][IN_W-1:0] mag2_q;
  logic [LANES-1:0]           neg2_q;

  always_ff @(posedge clk_i) begin
    if (en) begin
      for (int k = 0; k < LANES; k++) begin
        sqr_q[k] <= SQ_W'(mag_q[k]) * SQ_W'(mag_q[k]);
      end
      mag2_q <= mag_q;
      neg2_q <= neg_q;
    end
  end

  // Front stage 3: sum of squares. Three squares of at most 2^62 fit in 64 bits.
  logic [SQ_W-1:0]            sum_q;
  logic [LANES-1:0][IN_W-1:0] mag3_q;
  logic [LANES-1:0]           neg3_q;

  always_ff @(posedge clk_i) begin
    if (en) begin
      sum_q  <= sqr_q[0] + sqr_q[1] + sqr_q[2];
      mag3_q <= mag2_q;
      neg3_q <= neg2_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
      v3_q <= 1'b0;
    end else if (en) begin
      v1_q <= in_valid_i;
      v2_q <= v1_q;
      v3_q <= v2_q;
    end
  end

  // Square root chain: each cell settles one bit of the floor root.
  sq_t sq_c [0:RSTEPS];

  always_comb begin
    sq_c[0].valid = v3_q;
    sq_c[0].n     = sum_q;
    sq_c[0].rem   = '0;
    sq_c[0].root  = '0;
    sq_c[0].mag   = mag3_q;
    sq_c[0].neg   = neg3_q;
  end

  for (genvar i = 0; i < RSTEPS; i++) begin : g_sqrt
    vn_sqrt_cell u_cell (
      .clk_i  (clk_i),
      .rst_ni (rst_ni),
      .en_i   (en),
      .d_i    (sq_c[i]),
      .q_o    (sq_c[i+1])
    );
  end

  // Divider chain: quotient (mag << 15) / len is at most 2^15, so 16 bits
  // suffice, starting with the divisor aligned at bit 15.
  dv_t dv_c [0:QSTEPS];

  always_comb begin
    dv_c[0].valid = sq_c[RSTEPS].valid;
    dv_c[0].degen = (sq_c[RSTEPS].root <= ROOT_W'(min_len_q));
    dv_c[0].neg   = sq_c[RSTEPS].neg;
    dv_c[0].dsr   = {sq_c[RSTEPS].root, {(OUT_W-1){1'b0}}};
    dv_c[0].q     = '0;
    for (int k = 0; k < LANES; k++) begin
      dv_c[0].rem[k] = {sq_c[RSTEPS].mag[k], {(OUT_W-1){1'b0}}};
    end
  end

  for (genvar i = 0; i < QSTEPS; i++) begin : g_div
    vn_div_cell u_cell (
      .clk_i  (clk_i),
      .rst_ni (rst_ni),
      .en_i   (en),
      .d_i    (dv_c[i]),
      .q_o    (dv_c[i+1])
    );
  end

  // Sign, saturation of an exact +1.0, and forcing of degenerate vectors.
  localparam logic [OUT_W-1:0] PMAX = {1'b0, {(OUT_W-1){1'b1}}};
  logic [LANES-1:0][OUT_W-1:0] res;

  always_comb begin
    for (int k = 0; k < LANES; k++) begin
      if (dv_c[QSTEPS].degen) begin
        res[k] = '0;
      end else if (dv_c[QSTEPS].neg[k]) begin
        res[k] = OUT_W'(-dv_c[QSTEPS].q[k]);
      end else if (dv_c[QSTEPS].q[k] > PMAX) begin
        res[k] = PMAX;
      end else begin
        res[k] = dv_c[QSTEPS].q[k];
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_o <= 1'b0;
    end else if (en) begin
      out_valid_o <= dv_c[QSTEPS].valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      x_out_o      <= res[0];
      y_out_o      <= res[1];
      z_out_o      <= res[2];
      degenerate_o <= dv_c[QSTEPS].degen;
    end
  end

endmodule
`default_nettype wire
